### sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS       = 32768;
  localparam int FIRST_DATA_BLOCK = 64;

  localparam int BMP_WORDS  = (NUM_BLOCKS + 31) / 32;
  localparam int WORD_AW    = $clog2(BMP_WORDS);
  localparam int BLK_W      = WORD_AW + 5;
  localparam int FIRST_WORD = FIRST_DATA_BLOCK / 32;
  localparam int FREE_INIT_I = (NUM_BLOCKS > FIRST_DATA_BLOCK) ?
                               ((NUM_BLOCKS - FIRST_DATA_BLOCK) % 65536) : 0;

  localparam logic [15:0] FREE_INIT  = 16'(FREE_INIT_I);
  localparam logic [31:0] FIRST_MASK = ~((32'd1 << (FIRST_DATA_BLOCK % 32)) - 32'd1);

  typedef logic [WORD_AW-1:0] word_addr_t;
  typedef logic [WORD_AW:0]   word_cnt_t;
  typedef logic [BLK_W-1:0]   blk_t;
  typedef logic [BLK_W:0]     blk_ext_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_SYSTEM  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_ALREADY = 3'd4
  } bba_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FREE_CHK,
    S_SCAN,
    S_DONE
  } bba_state_e;

  typedef struct packed {
    logic        clr_step;
    logic        take_req;
    logic        scan_init;
    logic        scan_step;
    logic        free_read;
    logic        alloc_commit;
    logic        free_commit;
    logic        res_set;
    bba_status_e res_code;
    logic        load_out;
  } bba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_free;
    logic free_zero;
    logic blk_system;
    logic blk_range;
    logic chk_valid;
    logic chk_found;
    logic chk_beyond;
    logic chk_last;
    logic bit_set;
    logic out_room;
  } bba_sts_t;

  // reset contents of one bitmap word: system blocks marked used
  function automatic logic [31:0] init_word(input word_addr_t w);
    logic [31:0] r;
    blk_t        b;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      b    = {w, 5'(k)};
      r[k] = ({1'b0, b} < blk_ext_t'(FIRST_DATA_BLOCK));
    end
    return r;
  endfunction

endpackage

### sv/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: opcode and block number with valid/ready.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] block_num;

  modport source (output valid, output opcode, output block_num, input ready);
  modport sink   (input valid, input opcode, input block_num, output ready);
endinterface

### sv/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: status, allocated block and free count with valid/ready.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [14:0] alloc_block;
  logic [15:0] free_count;

  modport source (output valid, output status, output alloc_block, output free_count,
                  input ready);
  modport sink   (input valid, input status, input alloc_block, input free_count,
                  output ready);
endinterface

### sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a one-bit-per-block usage bitmap.
// ----------------------------------------------------------------------------
//   channel  dir  fields
//   req_i    in   opcode (0 alloc, 1 free), block_num[15:0]
//   rsp_o    out  status[2:0], alloc_block[14:0], free_count[15:0]
//
// after reset a clearing pass writes all BMP_WORDS (1024) bitmap words, one a
// cycle; no request is taken until it ends.
// a free passes the decode, bit-check and reply states; a request rejected
// without a bitmap read goes from decode to reply; an allocate scans up to
// 1022 bitmap words from the first data word through the single read port.
// one request is in flight at a time; a finished reply sits in an output
// register, and a stalled reply holds the sequencer in its reply state.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
  input logic        clk_i,
  input logic        rst_ni,
  bba_req_if.sink    req_i,
  bba_rsp_if.source  rsp_o
);

  bba_pkg::bba_cmd_t cmd;
  bba_pkg::bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_opcode_i      (req_i.opcode),
    .req_block_num_i   (req_i.block_num),
    .out_valid_o       (rsp_o.valid),
    .out_ready_i       (rsp_o.ready),
    .out_status_o      (rsp_o.status),
    .out_alloc_block_o (rsp_o.alloc_block),
    .out_free_count_o  (rsp_o.free_count)
  );

endmodule

### sv/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clearing pass, request decode, scan and reply.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t cmd_o
);

  bba_pkg::bba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        if (sts_i.clear_last) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (req_valid_i) state_d = bba_pkg::S_DECODE;
      end
      bba_pkg::S_DECODE: begin
        if (!sts_i.op_free) begin
          state_d = sts_i.free_zero ? bba_pkg::S_DONE : bba_pkg::S_SCAN;
        end else if (sts_i.blk_system || sts_i.blk_range) begin
          state_d = bba_pkg::S_DONE;
        end else begin
          state_d = bba_pkg::S_FREE_CHK;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        state_d = bba_pkg::S_DONE;
      end
      bba_pkg::S_SCAN: begin
        if (sts_i.chk_valid && (sts_i.chk_found || sts_i.chk_last)) begin
          state_d = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_DONE: begin
        if (sts_i.out_room) state_d = bba_pkg::S_IDLE;
      end
      default: state_d = bba_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      bba_pkg::S_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.take_req = req_valid_i;
      end
      bba_pkg::S_DECODE: begin
        if (!sts_i.op_free) begin
          if (sts_i.free_zero) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = bba_pkg::ST_NOSPACE;
          end else begin
            cmd_o.scan_init = 1'b1;
          end
        end else if (sts_i.blk_system) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = bba_pkg::ST_SYSTEM;
        end else if (sts_i.blk_range) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = bba_pkg::ST_RANGE;
        end else begin
          cmd_o.free_read = 1'b1;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        cmd_o.res_set = 1'b1;
        if (sts_i.bit_set) begin
          cmd_o.free_commit = 1'b1;
          cmd_o.res_code    = bba_pkg::ST_OK;
        end else begin
          cmd_o.res_code = bba_pkg::ST_ALREADY;
        end
      end
      bba_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.chk_valid) begin
          if (sts_i.chk_found && !sts_i.chk_beyond) begin
            cmd_o.alloc_commit = 1'b1;
            cmd_o.res_set      = 1'b1;
            cmd_o.res_code     = bba_pkg::ST_OK;
          end else if (sts_i.chk_found || sts_i.chk_last) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = bba_pkg::ST_NOSPACE;
          end
        end
      end
      bba_pkg::S_DONE: begin
        cmd_o.load_out = sts_i.out_room;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### sv/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: bitmap RAM, scan pipeline, free counter, reply register.
// ----------------------------------------------------------------------------
module bba_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::bba_cmd_t cmd_i,
  output bba_pkg::bba_sts_t sts_o,
  input  logic              req_opcode_i,
  input  logic [15:0]       req_block_num_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_status_o,
  output logic [14:0]       out_alloc_block_o,
  output logic [15:0]       out_free_count_o
);

  bba_pkg::word_cnt_t  cnt_q;
  bba_pkg::word_addr_t chk_addr_q;
  logic                chk_v_q;
  logic                op_q;
  logic [15:0]         blk_q;
  logic [15:0]         free_q;
  bba_pkg::bba_status_e res_status_q;
  logic [14:0]         res_block_q;
  logic                out_valid_q;
  logic [2:0]          out_status_q;
  logic [14:0]         out_block_q;
  logic [15:0]         out_free_q;

  logic                ram_we, ram_re;
  bba_pkg::word_addr_t ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, ram_rdata;

  bba_pkg::word_addr_t blk_word;
  logic                scan_issue;
  logic [31:0]         inv_word;
  logic [4:0]          low_idx;
  bba_pkg::blk_t       found_blk;

  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      if (v[k]) r = 5'(k);
    end
    return r;
  endfunction

  assign blk_word   = blk_q[bba_pkg::WORD_AW+4:5];
  assign scan_issue = cmd_i.scan_step && (cnt_q < bba_pkg::word_cnt_t'(bba_pkg::BMP_WORDS));

  // lowest clear bit of the word read in the previous cycle
  assign inv_word  = ~ram_rdata & ((chk_addr_q == bba_pkg::word_addr_t'(bba_pkg::FIRST_WORD)) ?
                                   bba_pkg::FIRST_MASK : 32'hFFFF_FFFF);
  assign low_idx   = lowest_set(inv_word);
  assign found_blk = {chk_addr_q, low_idx};

  always_comb begin
    ram_we    = cmd_i.clr_step || cmd_i.alloc_commit || cmd_i.free_commit;
    ram_waddr = blk_word;
    ram_wdata = ram_rdata & ~(32'd1 << blk_q[4:0]);
    if (cmd_i.clr_step) begin
      ram_waddr = cnt_q[bba_pkg::WORD_AW-1:0];
      ram_wdata = bba_pkg::init_word(cnt_q[bba_pkg::WORD_AW-1:0]);
    end else if (cmd_i.alloc_commit) begin
      ram_waddr = chk_addr_q;
      ram_wdata = ram_rdata | (32'd1 << low_idx);
    end
    ram_re    = scan_issue || cmd_i.free_read;
    ram_raddr = cmd_i.free_read ? blk_word : cnt_q[bba_pkg::WORD_AW-1:0];
  end

  bba_ram #(
    .Width (32),
    .Depth (bba_pkg::BMP_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      chk_v_q     <= 1'b0;
      free_q      <= bba_pkg::FREE_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        cnt_q <= cnt_q + bba_pkg::word_cnt_t'(1);
      end else if (cmd_i.scan_init) begin
        cnt_q <= bba_pkg::word_cnt_t'(bba_pkg::FIRST_WORD);
      end else if (scan_issue) begin
        cnt_q <= cnt_q + bba_pkg::word_cnt_t'(1);
      end
      chk_v_q <= scan_issue;
      if (cmd_i.alloc_commit) begin
        free_q <= free_q - 16'd1;
      end else if (cmd_i.free_commit) begin
        free_q <= free_q + 16'd1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      chk_addr_q <= cnt_q[bba_pkg::WORD_AW-1:0];
    end
    if (cmd_i.take_req) begin
      op_q  <= req_opcode_i;
      blk_q <= req_block_num_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_block_q  <= cmd_i.alloc_commit ? 15'(found_blk) : 15'd0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_block_q  <= res_block_q;
      out_free_q   <= free_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = (cnt_q[bba_pkg::WORD_AW-1:0] ==
                        bba_pkg::word_addr_t'(bba_pkg::BMP_WORDS - 1));
    sts_o.op_free    = (op_q == bba_pkg::OP_FREE);
    sts_o.free_zero  = (free_q == 16'd0);
    sts_o.blk_system = (blk_q < 16'(bba_pkg::FIRST_DATA_BLOCK));
    sts_o.blk_range  = ({1'b0, blk_q} >= 17'(bba_pkg::NUM_BLOCKS));
    sts_o.chk_valid  = chk_v_q;
    sts_o.chk_found  = |inv_word;
    sts_o.chk_beyond = ({1'b0, found_blk} >= bba_pkg::blk_ext_t'(bba_pkg::NUM_BLOCKS));
    sts_o.chk_last   = (chk_addr_q == bba_pkg::word_addr_t'(bba_pkg::BMP_WORDS - 1));
    sts_o.bit_set    = ram_rdata[blk_q[4:0]];
    sts_o.out_room   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_alloc_block_o = out_block_q;
  assign out_free_count_o  = out_free_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= bba_pkg::FREE_INIT)
    else $error("free count above its reset value");

  a_alloc_data_blk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |-> ({1'b0, found_blk} >= bba_pkg::blk_ext_t'(bba_pkg::FIRST_DATA_BLOCK)))
    else $error("allocation picked a system block");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |=> (free_q == $past(free_q) - 16'd1))
    else $error("free count not decremented on allocation");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("reply register overwritten before transfer");

endmodule
